@@ rtl/core/ptbs_pkg.sv @@
`timescale 1ns / 1ps
package ptbs_pkg;
   localparam int DEF_MAX_ROWS  = 64;
   localparam int DEF_WORD_BITS = 32;
   localparam int FRAC_BITS     = 16;
   localparam int ROW_CNT_BITS  = 7;
   localparam int SYS_CNT_BITS  = 11;
   localparam int IDX_BITS      = 6;
   localparam int FIELD_BITS    = 32;
   localparam int CSR_IDX_BITS  = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_COUNT    = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SYSTEM_COUNT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FWD_MUL1,
      ST_FWD_MUL2,
      ST_FWD_ACC,
      ST_BACK_RD,
      ST_BACK_MUL,
      ST_BACK_OUT
   } state_type;

   typedef struct packed {
      logic load;      // capture input beat
      logic fwd_mul1;  // a*f[r-1], rhs - ... - sum
      logic fwd_mul2;  // b * diff
      logic fwd_acc;   // store f, accumulate h*f
      logic back_rd;   // read stores for row
      logic back_mul;  // products
      logic back_out;  // form x, write rsp register
   } cmd_type;

   typedef struct packed {
      logic is_last;   // current row closes the system
      logic back_done; // back substitution at row zero
      logic rsp_full;  // output register occupied
   } sts_type;
endpackage

@@ rtl/core/ptbs_if.sv @@
`timescale 1ns / 1ps
interface ptbs_req_if;
   import ptbs_pkg::*;
   logic valid;
   logic ready;
   logic signed [FIELD_BITS-1:0] row_a;
   logic signed [FIELD_BITS-1:0] row_b_inv;
   logic signed [FIELD_BITS-1:0] row_c;
   logic signed [FIELD_BITS-1:0] row_g;
   logic signed [FIELD_BITS-1:0] row_h;
   logic signed [FIELD_BITS-1:0] row_rhs;
   modport source (output valid, row_a, row_b_inv, row_c, row_g, row_h, row_rhs,
                   input ready);
   modport sink (input valid, row_a, row_b_inv, row_c, row_g, row_h, row_rhs,
                 output ready);
endinterface

interface ptbs_rsp_if;
   import ptbs_pkg::*;
   logic valid;
   logic ready;
   logic signed [FIELD_BITS-1:0] solution;
   logic [IDX_BITS-1:0] row_index;
   logic row_last;
   logic batch_last;
   modport source (output valid, solution, row_index, row_last, batch_last,
                   input ready);
   modport sink (input valid, solution, row_index, row_last, batch_last,
                 output ready);
endinterface

@@ rtl/core/ptbs_ctrl.sv @@
`timescale 1ns / 1ps
module ptbs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptbs_pkg::sts_type sts,
   output ptbs_pkg::cmd_type cmd
);
   import ptbs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_FWD_MUL1;
         ST_FWD_MUL1: state_in = ST_FWD_MUL2;
         ST_FWD_MUL2: state_in = ST_FWD_ACC;
         ST_FWD_ACC:  state_in = sts.is_last ? ST_BACK_OUT : ST_IDLE;
         ST_BACK_RD:  state_in = ST_BACK_MUL;
         ST_BACK_MUL: state_in = ST_BACK_OUT;
         ST_BACK_OUT: begin
            if (!sts.rsp_full) state_in = sts.back_done ? ST_IDLE : ST_BACK_RD;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_FWD_MUL1: cmd.fwd_mul1 = 1'b1;
         ST_FWD_MUL2: cmd.fwd_mul2 = 1'b1;
         ST_FWD_ACC:  cmd.fwd_acc  = 1'b1;
         ST_BACK_RD:  cmd.back_rd  = 1'b1;
         ST_BACK_MUL: cmd.back_mul = 1'b1;
         ST_BACK_OUT: cmd.back_out = !sts.rsp_full;
         default:     cmd = '0;
      endcase
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_load_next: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_FWD_MUL1) else $error("load not followed");
   a_back_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BACK_OUT && sts.rsp_full) |=> state_ff == ST_BACK_OUT)
      else $error("back out left while full");
`endif
endmodule

@@ rtl/core/ptbs_dp.sv @@
`timescale 1ns / 1ps
module ptbs_dp #(
   parameter int MAX_ROWS  = ptbs_pkg::DEF_MAX_ROWS,
   parameter int WORD_BITS = ptbs_pkg::DEF_WORD_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ptbs_pkg::cmd_type                      cmd,
   output ptbs_pkg::sts_type                      sts,
   input  logic                                   csr_write,
   input  logic [ptbs_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [ptbs_pkg::SYS_CNT_BITS-1:0]      csr_data,
   input  logic signed [ptbs_pkg::FIELD_BITS-1:0] row_a,
   input  logic signed [ptbs_pkg::FIELD_BITS-1:0] row_b_inv,
   input  logic signed [ptbs_pkg::FIELD_BITS-1:0] row_c,
   input  logic signed [ptbs_pkg::FIELD_BITS-1:0] row_g,
   input  logic signed [ptbs_pkg::FIELD_BITS-1:0] row_h,
   input  logic signed [ptbs_pkg::FIELD_BITS-1:0] row_rhs,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [ptbs_pkg::FIELD_BITS-1:0] rsp_solution,
   output logic [ptbs_pkg::IDX_BITS-1:0]          rsp_row_index,
   output logic                                   rsp_row_last,
   output logic                                   rsp_batch_last
);
   import ptbs_pkg::*;

   localparam int SAT_BITS = (WORD_BITS > 32) ? 32 : WORD_BITS;
   localparam int AW       = $clog2(MAX_ROWS);
   localparam int PW       = 2 * FIELD_BITS;
   localparam int SW       = PW + 2;
   localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (SAT_BITS - 1)) - SW'(1);
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

   function automatic logic signed [FIELD_BITS-1:0] sat_fn(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      r = v;
      if (v > SAT_HI) r = SAT_HI;
      if (v < SAT_LO) r = SAT_LO;
      return FIELD_BITS'(r);
   endfunction

   function automatic logic signed [SW-1:0] qmul_fn(input logic signed [FIELD_BITS-1:0] x,
                                                   input logic signed [FIELD_BITS-1:0] y);
      logic signed [PW-1:0] p;
      p = x * y;
      return SW'(p >>> FRAC_BITS);
   endfunction

   logic signed [FIELD_BITS-1:0] super_mem [MAX_ROWS];
   logic signed [FIELD_BITS-1:0] column_mem [MAX_ROWS];
   logic signed [FIELD_BITS-1:0] sol_mem [MAX_ROWS];

   logic [ROW_CNT_BITS-1:0] row_count_ff;
   logic [SYS_CNT_BITS-1:0] system_count_ff;
   logic [ROW_CNT_BITS-1:0] row_ff;
   logic [SYS_CNT_BITS-2:0] sys_ff;
   logic signed [FIELD_BITS-1:0] corr_ff;
   logic [AW-1:0] back_ff;
   logic [AW-1:0] last_ff;
   logic blast_ff;

   logic signed [FIELD_BITS-1:0] a_ff, b_ff, c_ff, g_ff, h_ff, rhs_ff;
   logic signed [FIELD_BITS-1:0] prev_ff, diff_ff, f_ff, xl_ff, nxt_ff;
   logic signed [FIELD_BITS-1:0] rd_sol_ff, rd_sup_ff, rd_col_ff;
   logic signed [SW-1:0] pc_ff, pg_ff;
   logic rsp_valid_ff;
   logic signed [FIELD_BITS-1:0] rsp_sol_ff;
   logic [IDX_BITS-1:0] rsp_idx_ff;
   logic rsp_rl_ff, rsp_bl_ff;

   logic [ROW_CNT_BITS-1:0] n_eff;
   logic [SYS_CNT_BITS-1:0] s_eff;
   logic [AW-1:0] r_idx;
   logic is_last, is_first, do_acc;
   logic signed [FIELD_BITS-1:0] x_val;

   always_comb begin
      n_eff = row_count_ff;
      if (row_count_ff < ROW_CNT_BITS'(2)) n_eff = ROW_CNT_BITS'(2);
      if (row_count_ff > ROW_CNT_BITS'(MAX_ROWS)) n_eff = ROW_CNT_BITS'(MAX_ROWS);
      s_eff = system_count_ff;
      if (system_count_ff == '0) s_eff = SYS_CNT_BITS'(1);
      if (system_count_ff > SYS_CNT_BITS'(1024)) s_eff = SYS_CNT_BITS'(1024);
      r_idx = (row_ff >= ROW_CNT_BITS'(MAX_ROWS)) ? AW'(MAX_ROWS - 1) : row_ff[AW-1:0];
      is_last  = ({1'b0, r_idx} + (ROW_CNT_BITS + 1)'(1)) >= {1'b0, n_eff};
      is_first = (r_idx == '0);
      do_acc   = ({1'b0, r_idx} + (ROW_CNT_BITS + 1)'(3)) <= {1'b0, n_eff};
      if (back_ff == last_ff) x_val = f_ff;
      else if (back_ff + AW'(1) == last_ff) x_val = sat_fn(SW'(rd_sol_ff) - pc_ff);
      else x_val = sat_fn(SW'(rd_sol_ff) - pc_ff - pg_ff);
   end

   assign sts.is_last   = is_last;
   assign sts.back_done = (back_ff == '0);
   assign sts.rsp_full  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= ROW_CNT_BITS'(64);
         system_count_ff <= SYS_CNT_BITS'(1);
      end else if (csr_write) begin
         case (csr_index)
            CSR_ROW_COUNT:    row_count_ff    <= csr_data[ROW_CNT_BITS-1:0];
            CSR_SYSTEM_COUNT: system_count_ff <= csr_data;
            default:          row_count_ff    <= row_count_ff;
         endcase
      end
   end

   // Payload and stores
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= row_a; b_ff <= row_b_inv; c_ff <= row_c;
         g_ff <= row_g; h_ff <= row_h; rhs_ff <= row_rhs;
         prev_ff <= sol_mem[(r_idx == '0) ? r_idx : r_idx - AW'(1)];
      end
      if (cmd.fwd_mul1) begin
         diff_ff <= is_first ? rhs_ff
                    : (is_last ? sat_fn(SW'(rhs_ff) - qmul_fn(a_ff, prev_ff) - SW'(corr_ff))
                               : sat_fn(SW'(rhs_ff) - qmul_fn(a_ff, prev_ff)));
      end
      if (cmd.fwd_mul2) f_ff <= sat_fn(qmul_fn(b_ff, diff_ff));
      if (cmd.fwd_acc) begin
         sol_mem[r_idx]    <= f_ff;
         super_mem[r_idx]  <= c_ff;
         column_mem[r_idx] <= g_ff;
         last_ff <= r_idx;
         back_ff <= r_idx;
         xl_ff   <= f_ff;
         blast_ff <= ({1'b0, sys_ff} + SYS_CNT_BITS'(1)) >= s_eff;
      end
      if (cmd.back_rd) begin
         rd_sol_ff <= sol_mem[back_ff];
         rd_sup_ff <= super_mem[back_ff];
         rd_col_ff <= column_mem[back_ff];
      end
      if (cmd.back_mul) begin
         pc_ff <= qmul_fn(rd_sup_ff, nxt_ff);
         pg_ff <= qmul_fn(rd_col_ff, xl_ff);
      end
      if (cmd.back_out) begin
         rsp_sol_ff <= x_val;
         rsp_idx_ff <= IDX_BITS'(back_ff);
         rsp_rl_ff  <= (back_ff == '0);
         rsp_bl_ff  <= (back_ff == '0) && blast_ff;
         nxt_ff     <= x_val;
         back_ff    <= back_ff - AW'(1);
      end
   end

   // Control counters, accumulator and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0; sys_ff <= '0; corr_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.fwd_acc) begin
            if (!is_last) begin
               row_ff <= row_ff + ROW_CNT_BITS'(1);
               if (do_acc) corr_ff <= sat_fn(SW'(corr_ff) + qmul_fn(h_ff, f_ff));
            end else begin
               row_ff  <= '0;
               corr_ff <= '0;
               sys_ff  <= (({1'b0, sys_ff} + SYS_CNT_BITS'(1)) >= s_eff) ? '0
                          : sys_ff + (SYS_CNT_BITS - 1)'(1);
            end
         end
         if (cmd.back_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_solution   = rsp_sol_ff;
   assign rsp_row_index  = rsp_idx_ff;
   assign rsp_row_last   = rsp_rl_ff;
   assign rsp_batch_last = rsp_bl_ff;

`ifndef SYNTHESIS
   a_bl_rl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_batch_last) |-> rsp_row_last) else $error("batch_last w/o row_last");
   a_rl_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_row_last) |-> rsp_row_index == '0) else $error("row_last idx");
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= ROW_CNT_BITS'(MAX_ROWS)) else $error("row counter range");
`endif
endmodule

@@ rtl/core/periodic_tridiagonal_back_substitution.sv @@
`timescale 1ns / 1ps
// A non-last row steps through load, two dependent multiplies and store/accumulate.
// The last row takes those steps, then emits its own solution and, for each lower row,
// reads, multiplies and forms a result; the back pass holds while the result port stalls.
// New row beats are taken only in idle, after the previous row and any back pass; N rows give N results.
// Reset (synchronous, active high): counters and accumulator cleared, row_count 64,
// system_count 1; stores are undefined until written.
module periodic_tridiagonal_back_substitution #(
   parameter int MAX_ROWS  = ptbs_pkg::DEF_MAX_ROWS,
   parameter int WORD_BITS = ptbs_pkg::DEF_WORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [ptbs_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [ptbs_pkg::SYS_CNT_BITS-1:0] csr_data,
   ptbs_req_if.sink                          req,
   ptbs_rsp_if.source                        rsp
);
   import ptbs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Controller: sequences each row beat and, after the last row, the back pass.
   ptbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: stores, multipliers, accumulator, result register.
   ptbs_dp #(
      .MAX_ROWS  (MAX_ROWS),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .row_a          (req.row_a),
      .row_b_inv      (req.row_b_inv),
      .row_c          (req.row_c),
      .row_g          (req.row_g),
      .row_h          (req.row_h),
      .row_rhs        (req.row_rhs),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_solution   (rsp.solution),
      .rsp_row_index  (rsp.row_index),
      .rsp_row_last   (rsp.row_last),
      .rsp_batch_last (rsp.batch_last)
   );
endmodule
